// ----- src/qdec_pkg.sv -----
`timescale 1ns / 1ps

package qdec_pkg;

   // Register map, indexed by byte address bit 2.
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [0:0] REG_WINDOW_TICKS = 1'b0;
   localparam logic [0:0] REG_DEGREE_SCALE = 1'b1;

   localparam logic [15:0] WINDOW_TICKS_RESET = 16'd1000;
   localparam logic [15:0] DEGREE_SCALE_RESET = 16'd19663;

   // Direction codes of the last valid step.
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BWD  = 2'd2;

   // Step differences along the phase cycle.
   localparam logic [1:0] DIFF_FWD  = 2'd1;
   localparam logic [1:0] DIFF_JUMP = 2'd2;
   localparam logic [1:0] DIFF_BWD  = 2'd3;

   localparam logic [1:0] PHASE_RESET = 2'd3;

   typedef struct packed {
      logic [1:0] phase;
      logic       tick;
      logic       reset_position;
      logic       clear_error;
   } sample_type;

   typedef struct packed {
      logic [7:0]  position;
      logic [15:0] window_snap;
      logic        window_close;
      logic [1:0]  direction;
      logic        fault;
      logic        stepped;
   } step_info_type;

   // Place of a phase code on the cycle 01, 00, 10, 11.
   function automatic logic [1:0] cycle_pos(input logic [1:0] phase);
      logic [1:0] pos;
      case (phase)
         2'd0: pos = 2'd0;
         2'd1: pos = 2'd1;
         2'd2: pos = 2'd2;
         2'd3: pos = 2'd3;
         default: pos = 2'd0;
      endcase
      // Code 01 sits first, code 00 second.
      if (phase == 2'd0) begin
         pos = 2'd1;
      end else if (phase == 2'd1) begin
         pos = 2'd0;
      end
      return pos;
   endfunction

endpackage

// ----- src/quadrature_decoder_with_speed_unit.sv -----
`timescale 1ns / 1ps

// Quadrature x4 encoder decoder with position, angle and speed. Every item
// is one sample of the two encoder lines together with a millisecond tick
// and the position-reset and error-clear requests, and every item yields
// exactly one result item carrying the state after that sample. The block
// takes a new item in every clock cycle while the result side is not
// stalled. An accepted item passes in turn through the input register,
// the decoder state stage and the result register, which holds the
// results of the two scale multiplies.
// A stalled result side backs up through those registers, so up to three
// items may be in flight. The phase codes advance forward along the cycle
// 01, 00, 10, 11; a forward step adds one to the wrapping 8-bit position
// and to the signed angle count, a backward step subtracts one, and a
// two-code jump sets the sticky fault flag without moving anything. The
// angle output is the angle count times degree_scale (Q0.16), truncated
// toward zero. After window_ticks ticks the speed output latches the
// number of steps seen in that window times degree_scale, with eight
// fraction bits. Both registers sit on the APB port: window_ticks at
// byte address 0 and degree_scale at byte address 4, and they should be
// written only while no items are in flight.
module quadrature_decoder_with_speed_unit
   import qdec_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_phase,
   input  logic                     req_tick,
   input  logic                     req_reset_position,
   input  logic                     req_clear_error,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_position,
   output logic signed [23:0]       rsp_angle_degrees,
   output logic [23:0]              rsp_speed_q8,
   output logic [1:0]               rsp_direction,
   output logic                     rsp_fault,
   output logic                     rsp_stepped,

   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [15:0] window_ticks_ff;
   logic [15:0] degree_scale_ff;
   logic        csr_write;

   sample_type            sample;
   step_info_type         info;
   logic                  info_valid;
   logic                  info_ready;
   logic [ANGLE_BITS-1:0] angle_count;

   // The port never inserts wait states; a write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff <= WINDOW_TICKS_RESET;
         degree_scale_ff <= DEGREE_SCALE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_WINDOW_TICKS: window_ticks_ff <= csr_pwdata[15:0];
            REG_DEGREE_SCALE: degree_scale_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WINDOW_TICKS: csr_prdata = {16'd0, window_ticks_ff};
         REG_DEGREE_SCALE: csr_prdata = {16'd0, degree_scale_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign sample.phase          = req_phase;
   assign sample.tick           = req_tick;
   assign sample.reset_position = req_reset_position;
   assign sample.clear_error    = req_clear_error;

   // Phase decoding, counters and the speed window.
   qdec_core #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .sample       (sample),
      .window_ticks (window_ticks_ff),
      .out_valid    (info_valid),
      .out_ready    (info_ready),
      .info         (info),
      .angle_count  (angle_count)
   );

   // Angle and speed scaling into the result register.
   qdec_scale #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (info_valid),
      .in_ready      (info_ready),
      .info          (info),
      .angle_count   (angle_count),
      .degree_scale  (degree_scale_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .position      (rsp_position),
      .angle_degrees (rsp_angle_degrees),
      .speed_q8      (rsp_speed_q8),
      .direction     (rsp_direction),
      .fault         (rsp_fault),
      .stepped       (rsp_stepped)
   );

endmodule

// ----- src/qdec_core.sv -----
`timescale 1ns / 1ps

module qdec_core
   import qdec_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sample_type            sample,
   input  logic [15:0]           window_ticks,
   output logic                  out_valid,
   input  logic                  out_ready,
   output step_info_type         info,
   output logic [ANGLE_BITS-1:0] angle_count
);

   // Input register.
   logic       smp_valid_ff;
   sample_type smp_ff;

   // Decoder state; it always reflects the item held at the output.
   logic                  out_valid_ff;
   logic [1:0]            last_phase_ff, last_phase_in;
   logic [7:0]            position_ff, position_in;
   logic [ANGLE_BITS-1:0] angle_count_ff, angle_count_in;
   logic [15:0]           window_count_ff, window_count_in;
   logic [15:0]           elapsed_ff, elapsed_in;
   logic                  fault_ff, fault_in;
   logic [1:0]            direction_ff, direction_in;
   logic [15:0]           window_snap_ff;
   logic                  window_close_ff, window_close_in;
   logic                  stepped_ff, stepped_in;

   logic        advance;
   logic [16:0] elapsed_next;
   logic [15:0] window_base;
   logic [1:0]  diff;
   logic        fwd, bwd;

   assign advance  = smp_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !smp_valid_ff || advance;

   always_comb begin
      // Window handling comes first.
      elapsed_next    = {1'b0, elapsed_ff} + 17'd1;
      window_close_in = smp_ff.tick && (elapsed_next >= {1'b0, window_ticks});
      elapsed_in      = elapsed_ff;
      window_base     = window_count_ff;
      if (window_close_in) begin
         elapsed_in  = '0;
         window_base = '0;
      end else if (smp_ff.tick) begin
         elapsed_in = elapsed_next[15:0];
      end

      // Then the requests.
      position_in = smp_ff.reset_position ? 8'd0 : position_ff;
      fault_in    = smp_ff.clear_error ? 1'b0 : fault_ff;

      // Then the transition.
      diff = cycle_pos(smp_ff.phase) - cycle_pos(last_phase_ff);
      fwd  = (diff == DIFF_FWD);
      bwd  = (diff == DIFF_BWD);

      last_phase_in   = last_phase_ff;
      angle_count_in  = angle_count_ff;
      window_count_in = window_base;
      direction_in    = direction_ff;
      stepped_in      = fwd || bwd;

      if (fwd || bwd) begin
         last_phase_in  = smp_ff.phase;
         position_in    = fwd ? position_in + 8'd1 : position_in - 8'd1;
         angle_count_in = fwd ? angle_count_ff + ANGLE_BITS'(1)
                              : angle_count_ff - ANGLE_BITS'(1);
         direction_in   = fwd ? DIR_FWD : DIR_BWD;
         if (window_base != 16'hFFFF) begin
            window_count_in = window_base + 16'd1;
         end
      end else if (diff == DIFF_JUMP) begin
         fault_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
         last_phase_ff   <= PHASE_RESET;
         position_ff     <= '0;
         angle_count_ff  <= '0;
         window_count_ff <= '0;
         elapsed_ff      <= '0;
         fault_ff        <= 1'b0;
         direction_ff    <= DIR_NONE;
         window_close_ff <= 1'b0;
         stepped_ff      <= 1'b0;
      end else begin
         if (in_ready) begin
            smp_valid_ff <= in_valid;
         end
         if (advance) begin
            out_valid_ff    <= 1'b1;
            last_phase_ff   <= last_phase_in;
            position_ff     <= position_in;
            angle_count_ff  <= angle_count_in;
            window_count_ff <= window_count_in;
            elapsed_ff      <= elapsed_in;
            fault_ff        <= fault_in;
            direction_ff    <= direction_in;
            window_close_ff <= window_close_in;
            stepped_ff      <= stepped_in;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         smp_ff <= sample;
      end
      if (advance) begin
         // The window count before this item's step feeds the speed.
         window_snap_ff <= window_count_ff;
      end
   end

   assign out_valid          = out_valid_ff;
   assign angle_count        = angle_count_ff;
   assign info.position      = position_ff;
   assign info.window_snap   = window_snap_ff;
   assign info.window_close  = window_close_ff;
   assign info.direction     = direction_ff;
   assign info.fault         = fault_ff;
   assign info.stepped       = stepped_ff;

endmodule

// ----- src/qdec_scale.sv -----
`timescale 1ns / 1ps

module qdec_scale
   import qdec_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  step_info_type         info,
   input  logic [ANGLE_BITS-1:0] angle_count,
   input  logic [15:0]           degree_scale,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            position,
   output logic signed [23:0]    angle_degrees,
   output logic [23:0]           speed_q8,
   output logic [1:0]            direction,
   output logic                  fault,
   output logic                  stepped
);

   localparam int unsigned EXT_BITS = (ANGLE_BITS > 24) ? ANGLE_BITS : 24;

   logic                     valid_ff;
   logic [23:0]              speed_ff;
   logic [7:0]               position_ff;
   logic [23:0]              angle_ff;
   logic [1:0]               direction_ff;
   logic                     fault_ff;
   logic                     stepped_ff;

   logic                     take;
   logic                     neg;
   logic [ANGLE_BITS-1:0]    mag;
   logic [ANGLE_BITS+15:0]   angle_prod;
   logic [EXT_BITS-1:0]      quot;
   logic [EXT_BITS-1:0]      angle_in;
   logic [31:0]              speed_prod;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      // Sign and magnitude, so the product truncates toward zero.
      neg        = angle_count[ANGLE_BITS-1];
      mag        = neg ? (~angle_count + ANGLE_BITS'(1)) : angle_count;
      angle_prod = {16'd0, mag} * {{ANGLE_BITS{1'b0}}, degree_scale};
      quot       = EXT_BITS'(angle_prod[ANGLE_BITS+15:16]);
      angle_in   = neg ? (~quot + EXT_BITS'(1)) : quot;
      speed_prod = {16'd0, info.window_snap} * {16'd0, degree_scale};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         speed_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take && info.window_close) begin
            speed_ff <= speed_prod[31:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         position_ff  <= info.position;
         angle_ff     <= angle_in[23:0];
         direction_ff <= info.direction;
         fault_ff     <= info.fault;
         stepped_ff   <= info.stepped;
      end
   end

   assign out_valid     = valid_ff;
   assign position      = position_ff;
   assign angle_degrees = angle_ff;
   assign speed_q8      = speed_ff;
   assign direction     = direction_ff;
   assign fault         = fault_ff;
   assign stepped       = stepped_ff;

endmodule
